FILE: hw/rtl/dcq_pkg.sv
`timescale 1ns / 1ps

package dcq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_BITS    = 32;

    localparam int PORT_KEY_W = 32;
    localparam int COUNT_W    = 5;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 3;

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_POP    = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                rep;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    function automatic logic [KEY_BITS-1:0] key_from_port(input logic [PORT_KEY_W-1:0] k);
        logic [KEY_BITS+PORT_KEY_W-1:0] wide;
        wide = {{KEY_BITS{1'b0}}, k};
        return wide[KEY_BITS-1:0];
    endfunction

    function automatic logic [PORT_KEY_W-1:0] key_to_port(input logic [KEY_BITS-1:0] k);
        logic [KEY_BITS+PORT_KEY_W-1:0] wide;
        wide = {{PORT_KEY_W{1'b0}}, k};
        return wide[PORT_KEY_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] count_to_port(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, c};
        return wide[COUNT_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/dcq_ram.sv
`timescale 1ns / 1ps

module dcq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/dedup_command_queue.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Fields
// input     in         in_valid, in_stall   operation, cmd_key, repeat_flag
// output    out        out_valid, out_stall status, entry_valid, entry_key, entry_repeat, count
//
// One item is worked on at a time; in_stall is high from acceptance until the result is
// loaded into the output register. Peek, clear, pop of an empty queue and add to a full
// queue go straight to the result state. Add walks the stored keys through the RAM read
// port at one key per cycle. Remove walks to the match and then moves every later entry
// one slot toward the head; pop only moves. Reset clears the entry count, so no clearing
// pass is needed. A stalled result holds in the output register while the next item is
// accepted.

module dedup_command_queue
    import dcq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [PORT_KEY_W-1:0] cmd_key,
    input  logic                  repeat_flag,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic                  entry_valid,
    output logic [PORT_KEY_W-1:0] entry_key,
    output logic                  entry_repeat,
    output logic [COUNT_W-1:0]    count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                sh_vld_reg, sh_vld_next;
    logic                out_valid_reg, out_valid_next;

    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                rep_reg, rep_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    slot_t               head_reg, head_next;
    slot_t               pop_reg, pop_next;
    logic [CNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic [ADDR_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]   sh_dst_reg, sh_dst_next;

    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  ev_reg, ev_next;
    logic [PORT_KEY_W-1:0] ekey_reg, ekey_next;
    logic                  erep_reg, erep_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    slot_t             ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t             rd_slot;
    logic              hit;
    logic              accept;
    logic              out_free;

    dcq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_slot  = slot_t'(ram_rdata);
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign hit      = cmp_vld_reg && (rd_slot.key == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cmp_vld_next   = cmp_vld_reg;
        sh_vld_next    = sh_vld_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rep_next       = rep_reg;
        st_next        = st_reg;
        head_next      = head_reg;
        pop_next       = pop_reg;
        issue_idx_next = issue_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        rd_idx_next    = rd_idx_reg;
        sh_dst_next    = sh_dst_reg;
        status_next    = status_reg;
        ev_next        = ev_reg;
        ekey_next      = ekey_reg;
        erep_next      = erep_reg;
        count_next     = count_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '{key: key_reg, rep: rep_reg};
        ram_raddr      = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = operation;
                    key_next       = key_from_port(cmd_key);
                    rep_next       = repeat_flag;
                    st_next        = ST_OK;
                    issue_idx_next = '0;
                    cmp_vld_next   = 1'b0;
                    state_next     = S_DONE;
                    case (operation)
                        OP_ADD:
                        begin
                            if (fill_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_REMOVE:
                        begin
                            state_next = S_SEARCH;
                        end
                        OP_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                pop_next    = head_reg;
                                rd_idx_next = CNT_W'(1);
                                sh_vld_next = 1'b0;
                                state_next  = S_SHIFT;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (fill_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                        end
                        OP_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (issue_idx_reg < fill_reg)
                begin
                    ram_raddr      = issue_idx_reg[ADDR_W-1:0];
                    cmp_idx_next   = issue_idx_reg[ADDR_W-1:0];
                    cmp_vld_next   = 1'b1;
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end

                if (hit)
                begin
                    cmp_vld_next = 1'b0;
                    if (op_reg == OP_ADD)
                    begin
                        st_next    = ST_DUP;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_idx_next = CNT_W'(cmp_idx_reg) + CNT_W'(1);
                        sh_vld_next = 1'b0;
                        state_next  = S_SHIFT;
                    end
                end
                else if (!cmp_vld_reg && (issue_idx_reg >= fill_reg))
                begin
                    if (op_reg == OP_ADD)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_reg[ADDR_W-1:0];
                        if (fill_reg == '0)
                        begin
                            head_next = '{key: key_reg, rep: rep_reg};
                        end
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    else
                    begin
                        st_next = ST_NOTFOUND;
                    end
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                if (rd_idx_reg < fill_reg)
                begin
                    ram_raddr   = rd_idx_reg[ADDR_W-1:0];
                    sh_vld_next = 1'b1;
                    sh_dst_next = ADDR_W'(rd_idx_reg - CNT_W'(1));
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    sh_vld_next = 1'b0;
                end

                if (sh_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = sh_dst_reg;
                    ram_wdata = rd_slot;
                    if (sh_dst_reg == '0)
                    begin
                        head_next = rd_slot;
                    end
                end
                else if (rd_idx_reg >= fill_reg)
                begin
                    fill_next  = fill_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    count_next     = count_to_port(fill_reg);
                    if ((op_reg == OP_POP) && (st_reg == ST_OK))
                    begin
                        ev_next   = 1'b1;
                        ekey_next = key_to_port(pop_reg.key);
                        erep_next = pop_reg.rep;
                    end
                    else if (fill_reg != '0)
                    begin
                        ev_next   = 1'b1;
                        ekey_next = key_to_port(head_reg.key);
                        erep_next = head_reg.rep;
                    end
                    else
                    begin
                        ev_next   = 1'b0;
                        ekey_next = '0;
                        erep_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            sh_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cmp_vld_reg   <= cmp_vld_next;
            sh_vld_reg    <= sh_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        rep_reg       <= rep_next;
        st_reg        <= st_next;
        head_reg      <= head_next;
        pop_reg       <= pop_next;
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        rd_idx_reg    <= rd_idx_next;
        sh_dst_reg    <= sh_dst_next;
        status_reg    <= status_next;
        ev_reg        <= ev_next;
        ekey_reg      <= ekey_next;
        erep_reg      <= erep_next;
        count_reg     <= count_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_valid  = ev_reg;
    assign entry_key    = ekey_reg;
    assign entry_repeat = erep_reg;
    assign count        = count_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after an item was accepted");

    a_shift_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == S_SHIFT)) |-> (CNT_W'(ram_waddr) < fill_reg))
        else $error("compaction write beyond the stored entries");

    a_empty_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> (!entry_valid && (count == '0)))
        else $error("empty status reported with an entry");

    a_idle_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!cmp_vld_reg && !sh_vld_reg))
        else $error("walk pipeline active while idle");

endmodule
